FILE: rtl/orp_pkg.sv
`timescale 1ns / 1ps
package orp_pkg;

	// reply limits
	localparam logic [9:0] MAX_CHARS = 10'd1023;
	localparam logic [7:0] MAX_BYTES = 8'd128;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// result status codes
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	// pattern match phases: 41 0C A B
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_41    = 3'd1;
	localparam logic [2:0] PH_0C    = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_FOUND = 3'd4;

	localparam logic [7:0] BYTE_MODE = 8'h41;
	localparam logic [7:0] BYTE_PID  = 8'h0C;

	// error texts, index 0 first, padded to eight
	typedef logic [0:7][7:0] txt_t;

	localparam txt_t TXT_NODATA = {8'h4E, 8'h4F, 8'h20, 8'h44, 8'h41, 8'h54, 8'h41, 8'h00};
	localparam txt_t TXT_UNABLE = {8'h55, 8'h4E, 8'h41, 8'h42, 8'h4C, 8'h45, 8'h00, 8'h00};
	localparam txt_t TXT_ERROR  = {8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00, 8'h00, 8'h00};
	localparam logic [2:0] LEN_NODATA = 3'd7;
	localparam logic [2:0] LEN_UNABLE = 3'd6;
	localparam logic [2:0] LEN_ERROR  = 3'd5;

	// one classified character as it travels through the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       zero;
		logic       hex_ok;
		logic [3:0] nibble;
		logic       last;
	} char_entry_t;

	// returns {hit, next progress}; first letter of each text occurs once
	function automatic logic [3:0] text_step(input logic [2:0] prog, input logic [7:0] c,
			input txt_t txt, input logic [2:0] len);
		logic [2:0] p;
		logic       hit;
		begin
			p = (prog >= len) ? 3'd0 : prog;
			if (c == txt[p])
				p = p + 3'd1;
			else
				p = (c == txt[0]) ? 3'd1 : 3'd0;
			hit = (p >= len);
			if (hit)
				p = 3'd0;
			return {hit, p};
		end
	endfunction

endpackage

FILE: rtl/orp_front.sv
`timescale 1ns / 1ps
module orp_front import orp_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        end_of_reply,
	output logic        push,
	output char_entry_t entry,
	input  logic        q_ready
);

	logic       is_dig;
	logic       is_uc;
	logic       is_lc;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	always_comb begin
		is_dig = (char_in >= 8'h30) && (char_in <= 8'h39);
		is_uc  = (char_in >= 8'h41) && (char_in <= 8'h46);
		is_lc  = (char_in >= 8'h61) && (char_in <= 8'h66);
		entry.ch     = char_in;
		entry.zero   = (char_in == 8'h00);
		entry.hex_ok = is_dig || is_uc || is_lc;
		entry.last   = end_of_reply;
		if (is_dig)
			entry.nibble = char_in[3:0];
		else if (is_uc || is_lc)
			entry.nibble = char_in[3:0] + 4'd9; // 'A'/'a' low nibble is 1
		else
			entry.nibble = 4'd0;
	end

endmodule

FILE: rtl/orp_queue.sv
`timescale 1ns / 1ps
module orp_queue import orp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_entry_t push_data,
	output logic        push_ready,
	input  logic        pop,
	output logic        head_valid,
	output char_entry_t head
);

	char_entry_t    mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != QAW'(0) + (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QAW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QAW+1)'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (QAW+1)'(QDEPTH)) && !do_pop |=> count_q == (QAW+1)'(QDEPTH))
		else $error("queue lost an entry while full");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q == (QAW+1)'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step");

endmodule

FILE: rtl/orp_back.sv
`timescale 1ns / 1ps
module orp_back import orp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  char_entry_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] rpm_quarters
);

	logic [2:0] nodata_q, unable_q, errtxt_q;
	logic       err_q, term_q, half_q;
	logic [9:0] chars_q;
	logic [3:0] nib_q;
	logic [7:0] bytes_q;
	logic [2:0] phase_q;
	logic [7:0] hi_q, lo_q;

	logic [2:0] nodata_n, unable_n, errtxt_n;
	logic       err_n, term_n, half_n;
	logic [9:0] chars_n;
	logic [3:0] nib_n;
	logic [7:0] bytes_n;
	logic [2:0] phase_n;
	logic [7:0] hi_n, lo_n;
	logic [3:0] r_nodata, r_unable, r_errtxt;
	logic [7:0] byte_v;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] rpm_q;

	// a last beat needs the output register free
	assign pop = head_valid && (!head.last || !out_valid_q || out_ready);

	always_comb begin
		nodata_n = nodata_q; unable_n = unable_q; errtxt_n = errtxt_q;
		err_n = err_q; term_n = term_q; half_n = half_q;
		chars_n = chars_q; nib_n = nib_q; bytes_n = bytes_q;
		phase_n = phase_q; hi_n = hi_q; lo_n = lo_q;
		r_nodata = text_step(nodata_q, head.ch, TXT_NODATA, LEN_NODATA);
		r_unable = text_step(unable_q, head.ch, TXT_UNABLE, LEN_UNABLE);
		r_errtxt = text_step(errtxt_q, head.ch, TXT_ERROR, LEN_ERROR);
		byte_v   = {nib_q, head.nibble};
		if (!term_q) begin
			if (head.zero) begin
				term_n = 1'b1;
			end else begin
				nodata_n = r_nodata[2:0];
				unable_n = r_unable[2:0];
				errtxt_n = r_errtxt[2:0];
				if (r_nodata[3] || r_unable[3] || r_errtxt[3])
					err_n = 1'b1;
				if (chars_q < MAX_CHARS) begin
					chars_n = chars_q + 10'd1;
					if (!head.hex_ok) begin
						half_n = 1'b0;
					end else if (!half_q) begin
						nib_n  = head.nibble;
						half_n = 1'b1;
					end else begin
						half_n = 1'b0;
						if (bytes_q < MAX_BYTES) begin
							bytes_n = bytes_q + 8'd1;
							case (phase_q)
								PH_IDLE: begin
									phase_n = (byte_v == BYTE_MODE) ? PH_41 : PH_IDLE;
								end
								PH_41: begin
									if (byte_v == BYTE_PID)
										phase_n = PH_0C;
									else
										phase_n = (byte_v == BYTE_MODE) ? PH_41 : PH_IDLE;
								end
								PH_0C: begin
									hi_n    = byte_v;
									phase_n = PH_HIGH;
								end
								PH_HIGH: begin
									lo_n    = byte_v;
									phase_n = PH_FOUND;
								end
								default: ;
							endcase
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodata_q <= '0; unable_q <= '0; errtxt_q <= '0;
			err_q <= 1'b0; term_q <= 1'b0; half_q <= 1'b0;
			chars_q <= '0; nib_q <= '0; bytes_q <= '0;
			phase_q <= PH_IDLE; hi_q <= '0; lo_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				nodata_q <= '0; unable_q <= '0; errtxt_q <= '0;
				err_q <= 1'b0; term_q <= 1'b0; half_q <= 1'b0;
				chars_q <= '0; nib_q <= '0; bytes_q <= '0;
				phase_q <= PH_IDLE; hi_q <= '0; lo_q <= '0;
			end else begin
				nodata_q <= nodata_n; unable_q <= unable_n; errtxt_q <= errtxt_n;
				err_q <= err_n; term_q <= term_n; half_q <= half_n;
				chars_q <= chars_n; nib_q <= nib_n; bytes_q <= bytes_n;
				phase_q <= phase_n; hi_q <= hi_n; lo_q <= lo_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			if (err_n) begin
				status_q <= ST_ERROR;
				rpm_q    <= '0;
			end else if (phase_n == PH_FOUND) begin
				status_q <= ST_FOUND;
				rpm_q    <= {hi_n, lo_n};
			end else begin
				status_q <= ST_NONE;
				rpm_q    <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign rpm_quarters = rpm_q;

	a_rpm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_FOUND) |-> rpm_q == '0)
		else $error("rpm nonzero without a reading");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_FOUND) else $error("match phase out of range");
	a_byte_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= MAX_BYTES) else $error("byte count past limit");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(pop && head.last))
		else $error("result overwritten while held");

endmodule

FILE: rtl/obd_rpm_response_parser.sv
`timescale 1ns / 1ps
// Engine speed reply parser (mode 01, PID 0C).
// Input channel: one ASCII character per beat (char_in) with end_of_reply
// marking the final character; in_valid / in_ready handshake.
// Output channel: one result per reply, computed from the beat that carried
// end_of_reply: status (0 reading, 1 error text, 2 no reading) and
// rpm_quarters = (A << 8) | B, zero unless status is 0.
// Throughput: one character per cycle while in_ready is high. The front decodes hex and pushes
// into a 4-entry queue; the back updates the text matchers, byte packer
// and 41 0C matcher for one queue entry per cycle unless a result is held.
// Output path: the last character is registered in the queue, and the back
// registers out_valid when it pops that character from the queue.
// Reset: queue empty, all scan state cleared, no result pending.
// Receiver stall: the result is held in the output register; the back keeps
// consuming characters of the next reply but holds at its last character,
// and once the queue fills in_ready drops.
module obd_rpm_response_parser import orp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        end_of_reply,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] rpm_quarters
);

	logic        push;
	logic        q_ready;
	char_entry_t push_data;
	logic        pop;
	logic        head_valid;
	char_entry_t head;

	orp_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.end_of_reply (end_of_reply),
		.push         (push),
		.entry        (push_data),
		.q_ready      (q_ready)
	);

	orp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	orp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.rpm_quarters (rpm_quarters)
	);

endmodule
